// ===== rtl/rcsd_pkg.sv =====
package rcsd_pkg;

   localparam int ELEM_W    = 8;
   localparam int CODE_W    = 6;
   localparam int KEY_W     = 4;
   localparam int NUM_KEYS  = 10;
   localparam int SPAN      = 6;   // longest pattern
   localparam int SHORT_LEN = 4;   // shortest pattern, also the minimum fill before matching
   localparam int NUM_SETS  = 2;

   typedef logic [ELEM_W-1:0] elem_type;
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [KEY_W-1:0]  key_type;

   typedef struct packed {
      elem_type element_code;
      logic     value_nonzero;
      logic     batch_end;
   } req_type;

   typedef struct packed {
      logic    hit;
      key_type key;
      logic    held;
   } match_type;

   localparam elem_type CODE_LOW            = 8'd2;
   localparam elem_type CODE_HIGH           = 8'd35;
   localparam elem_type CODE_ALWAYS_DROPPED = 8'd5;
   localparam elem_type CODE_DROPPED_NEWER  = 8'd18;

   // Bit k describes key k+1.
   localparam logic [NUM_KEYS-1:0] KEY_IS_LONG  = 10'b11_1110_0000;
   localparam logic [NUM_KEYS-1:0] KEY_CAN_HOLD = 10'b00_0001_1011;

   // Patterns stored newest code first; short patterns pad with zero.
   localparam code_type PATTERNS [NUM_SETS][NUM_KEYS][SPAN] = '{
      '{
         '{6'h02, 6'h03, 6'h06, 6'h0E, 6'h00, 6'h00},
         '{6'h02, 6'h04, 6'h06, 6'h0E, 6'h00, 6'h00},
         '{6'h06, 6'h0E, 6'h06, 6'h0E, 6'h00, 6'h00},
         '{6'h06, 6'h0B, 6'h0C, 6'h0E, 6'h00, 6'h00},
         '{6'h06, 6'h0B, 6'h0D, 6'h0E, 6'h00, 6'h00},
         '{6'h06, 6'h07, 6'h0E, 6'h06, 6'h07, 6'h0E},
         '{6'h06, 6'h08, 6'h0E, 6'h06, 6'h08, 6'h0E},
         '{6'h06, 6'h09, 6'h0E, 6'h06, 6'h09, 6'h0E},
         '{6'h06, 6'h0A, 6'h0E, 6'h06, 6'h0A, 6'h0E},
         '{6'h06, 6'h0E, 6'h12, 6'h06, 6'h0E, 6'h12}
      },
      '{
         '{6'h02, 6'h03, 6'h13, 6'h1F, 6'h00, 6'h00},
         '{6'h02, 6'h04, 6'h13, 6'h1F, 6'h00, 6'h00},
         '{6'h13, 6'h1F, 6'h13, 6'h1F, 6'h00, 6'h00},
         '{6'h13, 6'h1C, 6'h1D, 6'h1F, 6'h00, 6'h00},
         '{6'h13, 6'h1C, 6'h1E, 6'h1F, 6'h00, 6'h00},
         '{6'h13, 6'h14, 6'h1F, 6'h13, 6'h14, 6'h1F},
         '{6'h13, 6'h15, 6'h1F, 6'h13, 6'h15, 6'h1F},
         '{6'h13, 6'h16, 6'h1F, 6'h13, 6'h16, 6'h1F},
         '{6'h13, 6'h17, 6'h1F, 6'h13, 6'h17, 6'h1F},
         '{6'h13, 6'h1F, 6'h23, 6'h13, 6'h1F, 6'h23}
      }
   };

endpackage

// ===== rtl/rcsd_req_if.sv =====
interface rcsd_req_if import rcsd_pkg::*; ();
   logic     valid;
   logic     ready;
   elem_type element_code;
   logic     value_nonzero;
   logic     batch_end;

   modport source (output valid, element_code, value_nonzero, batch_end, input ready);
   modport sink   (input valid, element_code, value_nonzero, batch_end, output ready);
endinterface

// ===== rtl/rcsd_rsp_if.sv =====
interface rcsd_rsp_if import rcsd_pkg::*; ();
   logic    valid;
   logic    ready;
   key_type key_code;
   logic    held;

   modport source (output valid, key_code, held, input ready);
   modport sink   (input valid, key_code, held, output ready);
endinterface

// ===== rtl/rcsd_csr_if.sv =====
interface rcsd_csr_if ();
   logic valid;
   logic ready;
   logic pattern_set;

   modport source (output valid, pattern_set, input ready);
   modport sink   (input valid, pattern_set, output ready);
endinterface

// ===== rtl/rcsd_match.sv =====
module rcsd_match import rcsd_pkg::*; (
   input  code_type        tail_code [SPAN],
   input  logic [SPAN-1:0] tail_value,
   input  logic            full_span,
   input  logic            pattern_set,
   output match_type       result
);

   always_comb begin
      logic [NUM_KEYS-1:0] hit;
      logic [NUM_KEYS-1:0] hold;
      hit    = '0;
      hold   = '0;
      result = '0;
      // Compare the tail against every pattern in parallel.
      for (int k = 0; k < NUM_KEYS; k++) begin
         hit[k] = !KEY_IS_LONG[k] || full_span;
         for (int j = 0; j < SPAN; j++) begin
            if (KEY_IS_LONG[k] || j < SHORT_LEN) begin
               hit[k] = hit[k] && (tail_code[j] == PATTERNS[pattern_set][k][j]);
            end
         end
         hold[k] = KEY_CAN_HOLD[k] &&
                   (KEY_IS_LONG[k] ? |tail_value : |tail_value[SHORT_LEN-1:0]);
      end
      // Lowest key number wins.
      for (int k = NUM_KEYS - 1; k >= 0; k--) begin
         if (hit[k]) begin
            result.hit  = 1'b1;
            result.key  = KEY_W'(k + 1);
            result.held = hold[k];
         end
      end
   end

endmodule

// ===== rtl/remote_cookie_sequence_decoder.sv =====
// Remote key sequence decoder.
//
// req   : one event word per handshake (element code, value-nonzero flag,
//         batch-end mark). Accepted when valid and ready are high at a clock edge.
// rsp   : one word per batch, sent on the event that carries batch_end: the
//         last key matched in the batch (0 when none) and its held flag.
// csr   : write channel for the pattern-set select; always ready. Write it
//         only while no event is in flight.
//
// Timing: an event is registered on acceptance and processed from the input
// register; the batch result is registered in the result register that drives
// rsp. Throughput is one event per cycle unless a batch-end word meets a full
// result slot: the shift of the code history, the ten parallel pattern compares
// and the key update all sit in the single stage between the two registers.
//
// Reset clears the history fill, the last key and held flag, the pattern set
// and both valid flags. When rsp stalls, the result register holds its word;
// events without batch_end keep flowing, and a second batch-end word waits in
// the input register until the result slot frees up.
module remote_cookie_sequence_decoder import rcsd_pkg::*; #(
   parameter int HISTORY_DEPTH = 6
) (
   input  logic       clock,
   input  logic       reset,
   rcsd_req_if.sink   req,
   rcsd_rsp_if.source rsp,
   rcsd_csr_if.sink   csr
);

   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

   // Input register
   req_type in_ff,       in_in;
   logic    in_valid_ff, in_valid_in;

   // Decoder state; code_hist_ff[0] is the newest entry
   code_type                 code_hist_ff [HISTORY_DEPTH];
   code_type                 code_hist_in [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] val_hist_ff,  val_hist_in;
   logic [CNT_W-1:0]         count_ff,     count_in;
   key_type                  last_key_ff,  last_key_in;
   logic                     last_held_ff, last_held_in;
   logic                     pattern_set_ff, pattern_set_in;

   // Result register
   logic    rsp_valid_ff, rsp_valid_in;
   key_type rsp_key_ff,   rsp_key_in;
   logic    rsp_held_ff,  rsp_held_in;

   // Processing stage
   code_type                 push_code [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] push_val;
   logic [CNT_W-1:0]         push_count;
   code_type                 tail_code [SPAN];
   logic                     slot_free;
   logic                     advance;
   logic                     req_fire;
   logic                     dropped;
   logic                     out_of_range;
   match_type                match;

   // Handshakes: the stage advances unless a batch end meets a full result slot.
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && (!in_ff.batch_end || slot_free);
   assign req.ready = !in_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.key_code = rsp_key_ff;
   assign rsp.held     = rsp_held_ff;

   // Classify the code
   assign dropped = (in_ff.element_code == CODE_ALWAYS_DROPPED) ||
                    ((in_ff.element_code == CODE_DROPPED_NEWER) && pattern_set_ff);
   assign out_of_range = (in_ff.element_code < CODE_LOW) ||
                         (in_ff.element_code > CODE_HIGH);

   // History after the push: shift everything one place older, newest in front.
   always_comb begin
      push_code[0] = in_ff.element_code[CODE_W-1:0];
      push_val[0]  = in_ff.value_nonzero;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
         push_code[i] = code_hist_ff[i-1];
         push_val[i]  = val_hist_ff[i-1];
      end
      // Saturate the fill at full depth; the oldest entry drops off the end.
      push_count = (count_ff == CNT_W'(HISTORY_DEPTH)) ? count_ff : count_ff + CNT_W'(1);
   end

   always_comb begin
      for (int i = 0; i < SPAN; i++) begin
         tail_code[i] = push_code[i];
      end
   end

   rcsd_match u_match (
      .tail_code   (tail_code),
      .tail_value  (push_val[SPAN-1:0]),
      .full_span   (push_count >= CNT_W'(SPAN)),
      .pattern_set (pattern_set_ff),
      .result      (match)
   );

   // Next state
   always_comb begin
      in_in          = in_ff;
      in_valid_in    = in_valid_ff;
      code_hist_in   = code_hist_ff;
      val_hist_in    = val_hist_ff;
      count_in       = count_ff;
      last_key_in    = last_key_ff;
      last_held_in   = last_held_ff;
      pattern_set_in = pattern_set_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_held_in    = rsp_held_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;

      if (csr.valid) begin
         pattern_set_in = csr.pattern_set;
      end

      if (advance) begin
         in_valid_in = 1'b0;
         if (!dropped) begin
            if (out_of_range) begin
               count_in = '0;
            end else begin
               code_hist_in = push_code;
               val_hist_in  = push_val;
               count_in     = push_count;
               // No match leaves the previous key standing.
               if (push_count >= CNT_W'(SHORT_LEN) && match.hit) begin
                  last_key_in  = match.key;
                  last_held_in = match.held;
               end
            end
         end
         // Report the batch and start the next one clean.
         if (in_ff.batch_end) begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = last_key_in;
            rsp_held_in  = last_held_in;
            count_in     = '0;
            last_key_in  = '0;
            last_held_in = 1'b0;
         end
      end

      if (req_fire) begin
         in_valid_in         = 1'b1;
         in_in.element_code  = req.element_code;
         in_in.value_nonzero = req.value_nonzero;
         in_in.batch_end     = req.batch_end;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         count_ff       <= '0;
         last_key_ff    <= '0;
         last_held_ff   <= 1'b0;
         pattern_set_ff <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         count_ff       <= count_in;
         last_key_ff    <= last_key_in;
         last_held_ff   <= last_held_in;
         pattern_set_ff <= pattern_set_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_ff        <= in_in;
      code_hist_ff <= code_hist_in;
      val_hist_ff  <= val_hist_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_held_ff  <= rsp_held_in;
   end

endmodule
